@@ rtl/rrd_pkg.sv @@
// Package for the raster row decompressor: constants, phase and state types.
// No dependencies.
package rrd_pkg;
   localparam int unsigned ROW_BYTES_DEF = 4096;
   localparam int unsigned SIZE_W = 13;
   localparam int unsigned IDX_W = 12;
   localparam int unsigned CSR_IDX_W = 1;
   localparam logic [CSR_IDX_W-1:0] CSR_MODE = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CSR_ROW_SIZE = 1'b1;

   typedef enum logic [1:0] {
      FUNC_BYTE = 2'd0,
      FUNC_EOR = 2'd1,
      FUNC_READ = 2'd2,
      FUNC_NONE = 2'd3
   } func_type;

   typedef enum logic [1:0] {
      MODE_RAW = 2'd0,
      MODE_RLE = 2'd1,
      MODE_PACK = 2'd2,
      MODE_DELTA = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      PH_CMD = 2'd0,
      PH_LIT = 2'd1,
      PH_RUN = 2'd2,
      PH_EXT = 2'd3
   } phase_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_FILL,
      ST_ZERO,
      ST_READ,
      ST_RESP
   } state_type;
endpackage

@@ rtl/rrd_req_if.sv @@
// Channel interface for request words.
// No dependencies.
interface rrd_req_if;
   logic valid;
   logic ready;
   logic [1:0] func;
   logic [7:0] data_byte;
   logic [11:0] read_index;
   modport source (output valid, func, data_byte, read_index, input ready);
   modport sink (input valid, func, data_byte, read_index, output ready);
endinterface

@@ rtl/rrd_rsp_if.sv @@
// Response channel interface carrying the read seed row byte and blank flag.
// No dependencies.
interface rrd_rsp_if;
   logic valid;
   logic ready;
   logic [7:0] read_byte;
   logic row_blank;
   modport source (output valid, read_byte, row_blank, input ready);
   modport sink (input valid, read_byte, row_blank, output ready);
endinterface

@@ rtl/rrd_ram.sv @@
// Generic single port RAM with registered read.
// No dependencies.
module rrd_ram #(
   parameter int unsigned WIDTH = 8,
   parameter int unsigned DEPTH = 4096
) (
   input logic clock,
   input logic wr_en,
   input logic [$clog2(DEPTH)-1:0] addr,
   input logic [WIDTH-1:0] wr_data,
   output logic [WIDTH-1:0] rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      rd_data <= mem[addr];
   end
endmodule

@@ rtl/raster_row_decompressor.sv @@
// Top level of the raster row decompressor: parser, write sequencer and seed row RAM.
// Depends on rrd_pkg, rrd_req_if, rrd_rsp_if and rrd_ram.
//
//   channel | direction | contents
//   req     | in        | func, data_byte, read_index
//   rsp     | out       | read_byte, row_blank
//   csr     | in        | mode, row_size writes
//
// A literal or command byte is taken in the idle state. A run writes its repeated bytes
// in the fill state, and end-of-row zeroing writes zero bytes in the zero state, through
// the single RAM write port. A read passes the read and response states and holds until
// the response word is taken. After reset a clearing pass zeroes the seed row, and no
// request word is accepted until it ends.
module raster_row_decompressor #(
   parameter int unsigned ROW_BYTES = rrd_pkg::ROW_BYTES_DEF
) (
   input logic clock,
   input logic reset,
   rrd_req_if.sink req,
   rrd_rsp_if.source rsp,
   input logic csr_we,
   input logic [rrd_pkg::CSR_IDX_W-1:0] csr_index,
   input logic [rrd_pkg::SIZE_W-1:0] csr_wdata
);
   import rrd_pkg::*;
   localparam int unsigned AW = $clog2(ROW_BYTES);
   localparam int unsigned PW = AW + 1;
   localparam logic [PW-1:0] ROW_LIM = PW'(ROW_BYTES);
   localparam logic [PW:0] OFF_SAT = (PW+1)'(ROW_BYTES + 1);

   state_type state_ff, state_in;
   mode_type mode_ff, mode_in;
   logic [SIZE_W-1:0] row_size_ff, row_size_in;
   phase_type phase_ff, phase_in;
   logic [PW-1:0] pos_ff, pos_in;
   logic [8:0] count_ff, count_in;
   logic [PW:0] offs_ff, offs_in;
   logic blank_ff, blank_in, seen_ff, seen_in, stop_ff, stop_in;
   logic [7:0] fill_ff, fill_in, rbyte_ff, rbyte_in;
   logic oob_ff, oob_in;
   logic [PW-1:0] eff_size;
   logic [PW:0] offs_sum, new_pos;
   logic [7:0] b;
   logic wr_en, accept;
   logic [AW-1:0] addr;
   logic [7:0] wr_data, rd_data;

   assign eff_size = (row_size_ff > SIZE_W'(ROW_BYTES)) ? ROW_LIM
                     : PW'(row_size_ff);
   assign b = req.data_byte;
   assign accept = req.valid && req.ready;
   assign rsp.read_byte = rbyte_ff;
   assign rsp.row_blank = blank_ff;

   rrd_ram #(.WIDTH(8), .DEPTH(ROW_BYTES)) u_ram (
      .clock(clock), .wr_en(wr_en), .addr(addr), .wr_data(wr_data), .rd_data(rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         mode_ff <= MODE_RAW;
         row_size_ff <= '0;
         phase_ff <= PH_CMD;
         pos_ff <= '0;
         count_ff <= '0;
         offs_ff <= '0;
         blank_ff <= 1'b1;
         seen_ff <= 1'b0;
         stop_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         mode_ff <= mode_in;
         row_size_ff <= row_size_in;
         phase_ff <= phase_in;
         pos_ff <= pos_in;
         count_ff <= count_in;
         offs_ff <= offs_in;
         blank_ff <= blank_in;
         seen_ff <= seen_in;
         stop_ff <= stop_in;
      end
      fill_ff <= fill_in;
      rbyte_ff <= rbyte_in;
      oob_ff <= oob_in;
   end

   always_comb begin
      state_in = state_ff;
      mode_in = mode_ff;
      row_size_in = row_size_ff;
      phase_in = phase_ff;
      pos_in = pos_ff;
      count_in = count_ff;
      offs_in = offs_ff;
      blank_in = blank_ff;
      seen_in = seen_ff;
      stop_in = stop_ff;
      fill_in = fill_ff;
      rbyte_in = rbyte_ff;
      oob_in = oob_ff;
      wr_en = 1'b0;
      addr = pos_ff[AW-1:0];
      wr_data = b;
      req.ready = 1'b0;
      rsp.valid = 1'b0;
      offs_sum = '0;
      new_pos = '0;
      case (state_ff)
         ST_CLEAR: begin
            wr_en = 1'b1;
            wr_data = '0;
            pos_in = pos_ff + 1'b1;
            if (pos_ff == ROW_LIM - 1'b1) begin
               pos_in = '0;
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            req.ready = 1'b1;
            if (accept) begin
               case (func_type'(req.func))
                  FUNC_BYTE: begin
                     seen_in = 1'b1;
                     if (!stop_ff) begin
                        if (mode_ff == MODE_RAW || phase_ff == PH_LIT) begin
                           if (pos_ff < eff_size) begin
                              wr_en = 1'b1;
                              pos_in = pos_ff + 1'b1;
                           end
                           if (mode_ff != MODE_RAW) begin
                              count_in = count_ff - 1'b1;
                              if (count_ff == 9'd1) begin
                                 phase_in = PH_CMD;
                              end
                           end
                        end else if (phase_ff == PH_RUN) begin
                           fill_in = b;
                           phase_in = PH_CMD;
                           if (count_ff != '0) begin
                              state_in = ST_FILL;
                           end
                        end else if (phase_ff == PH_EXT) begin
                           offs_sum = offs_ff + (PW+1)'(b);
                           if (offs_sum > OFF_SAT) begin
                              offs_sum = OFF_SAT;
                           end
                           offs_in = offs_sum;
                           if (b != 8'hff) begin
                              new_pos = (PW+1)'(pos_ff) + offs_sum;
                              if (new_pos >= (PW+1)'(eff_size)) begin
                                 stop_in = 1'b1;
                              end else begin
                                 pos_in = new_pos[PW-1:0];
                                 phase_in = PH_LIT;
                              end
                           end
                        end else begin
                           case (mode_ff)
                              MODE_RLE: begin
                                 count_in = {1'b0, b} + 9'd1;
                                 phase_in = PH_RUN;
                              end
                              MODE_PACK: begin
                                 if (b < 8'd128) begin
                                    count_in = {1'b0, b} + 9'd1;
                                    phase_in = PH_LIT;
                                 end else if (b > 8'd128) begin
                                    count_in = 9'd257 - {1'b0, b};
                                    phase_in = PH_RUN;
                                 end
                              end
                              default: begin
                                 count_in = {6'd0, b[7:5]} + 9'd1;
                                 offs_in = {{(PW-4){1'b0}}, b[4:0]};
                                 if (b[4:0] == 5'h1f) begin
                                    phase_in = PH_EXT;
                                 end else begin
                                    new_pos = (PW+1)'(pos_ff) + (PW+1)'(b[4:0]);
                                    if (new_pos >= (PW+1)'(eff_size)) begin
                                       stop_in = 1'b1;
                                    end else begin
                                       pos_in = new_pos[PW-1:0];
                                       phase_in = PH_LIT;
                                    end
                                 end
                              end
                           endcase
                        end
                     end
                  end
                  FUNC_EOR: begin
                     if (mode_ff != MODE_DELTA) begin
                        blank_in = !seen_ff;
                        if (!blank_ff) begin
                           state_in = ST_ZERO;
                        end else begin
                           pos_in = '0;
                        end
                     end else begin
                        blank_in = blank_ff && !seen_ff;
                        pos_in = '0;
                     end
                     phase_in = PH_CMD;
                     count_in = '0;
                     offs_in = '0;
                     seen_in = 1'b0;
                     stop_in = 1'b0;
                  end
                  FUNC_READ: begin
                     addr = req.read_index[AW-1:0];
                     oob_in = (PW+1)'(req.read_index) >= (PW+1)'(ROW_BYTES);
                     state_in = ST_READ;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_FILL: begin
            if (count_ff == '0) begin
               state_in = ST_IDLE;
            end else begin
               wr_data = fill_ff;
               if (pos_ff < eff_size) begin
                  wr_en = 1'b1;
                  pos_in = pos_ff + 1'b1;
               end
               count_in = count_ff - 1'b1;
            end
         end
         ST_ZERO: begin
            wr_data = '0;
            if (pos_ff < eff_size) begin
               wr_en = 1'b1;
               pos_in = pos_ff + 1'b1;
            end else begin
               pos_in = '0;
               state_in = ST_IDLE;
            end
         end
         ST_READ: begin
            rbyte_in = oob_ff ? 8'd0 : rd_data;
            state_in = ST_RESP;
         end
         ST_RESP: begin
            rsp.valid = 1'b1;
            if (rsp.ready) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
      if (csr_we) begin
         case (csr_index)
            CSR_MODE: begin
               mode_in = mode_type'(csr_wdata[1:0]);
               if (state_ff != ST_CLEAR) begin
                  pos_in = '0;
               end
               phase_in = PH_CMD;
               count_in = '0;
               offs_in = '0;
               seen_in = 1'b0;
               stop_in = 1'b0;
            end
            CSR_ROW_SIZE: row_size_in = csr_wdata;
            default: begin
            end
         endcase
      end
   end
endmodule
